[rtl/core/feedback_level_freq_classifier_assert.svh]
// Assertion macros for the feedback level and frequency classifier checker.
// Both expect clk and rst in the scope where they are used.
`ifndef FEEDBACK_LEVEL_FREQ_CLASSIFIER_ASSERT_SVH
`define FEEDBACK_LEVEL_FREQ_CLASSIFIER_ASSERT_SVH

// Condition must hold at every edge outside reset.
`define FBLC_ASSERT_HOLDS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FBLC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/fblc_pkg.sv]
// Shared types and constants for the feedback level and frequency classifier.
// No dependencies.
package fblc_pkg;

  localparam int CHANNELS_DEFAULT = 8;
  localparam int MASK_W           = 8;
  localparam int CH_W             = 3;
  localparam int LIMIT_W          = 7;
  localparam int COUNT_W          = 8;
  localparam int VALUES_W         = 16;
  localparam int CFG_INDEX_W      = 4;
  localparam int CFG_DATA_W       = 8;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ACTIVE_MASK,
    REG_PARTIAL_MASK,
    REG_DISABLE_MASK,
    REG_SAMPLES_PER_DECISION,
    REG_PLAIN_LEVEL_LIMIT,
    REG_PLAIN_FREQ_LIMIT,
    REG_ZC_LEVEL_LIMIT,
    REG_ZC_PHASE_LIMIT
  } cfg_reg_e;

  typedef enum logic [1:0] {
    VAL_LOW      = 2'd0,
    VAL_HIGH     = 2'd1,
    VAL_FREQ_IN  = 2'd2,
    VAL_FREQ_OPP = 2'd3
  } value_code_e;

  typedef enum logic {
    REQ_TICK    = 1'b0,
    REQ_RESTART = 1'b1
  } req_type_e;

  typedef struct packed {
    logic [LIMIT_W-1:0] samples_per_decision;
    logic [LIMIT_W-1:0] plain_level_limit;
    logic [LIMIT_W-1:0] plain_freq_limit;
    logic [LIMIT_W-1:0] zc_level_limit;
    logic [LIMIT_W-1:0] zc_phase_limit;
  } limits_t;

  typedef struct packed {
    logic [1:0] value;
    logic       ready;
    logic       wready;
    logic       decided;
  } lane_status_t;

  typedef struct packed {
    logic [VALUES_W-1:0] channel_values;
    logic [MASK_W-1:0]   ready_mask;
    logic [MASK_W-1:0]   writable_ready_mask;
    logic [MASK_W-1:0]   decided_mask;
    logic                all_active_ready;
  } result_t;

endpackage

[rtl/core/fblc_if.sv]
// Channel interfaces: request, result and configuration write.
// Depends on fblc_pkg for field widths.
interface fblc_req_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [fblc_pkg::CH_W-1:0]   channel;
  logic [fblc_pkg::MASK_W-1:0] pin_levels;
  logic                        load_type;
  logic                        zc_available;
  logic                        zc_await_rising;

  modport source (output valid, req_type, channel, pin_levels, load_type, zc_available,
                  zc_await_rising, input ready);
  modport sink (input valid, req_type, channel, pin_levels, load_type, zc_available,
                zc_await_rising, output ready);
endinterface

interface fblc_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [fblc_pkg::VALUES_W-1:0] channel_values;
  logic [fblc_pkg::MASK_W-1:0]   ready_mask;
  logic [fblc_pkg::MASK_W-1:0]   writable_ready_mask;
  logic [fblc_pkg::MASK_W-1:0]   decided_mask;
  logic                          all_active_ready;

  modport source (output valid, channel_values, ready_mask, writable_ready_mask, decided_mask,
                  all_active_ready, input ready);
  modport sink (input valid, channel_values, ready_mask, writable_ready_mask, decided_mask,
                all_active_ready, output ready);
endinterface

interface fblc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [fblc_pkg::CFG_INDEX_W-1:0] index;
  logic [fblc_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/fblc_lane.sv]
// One channel lane: level, phase and window counters plus the classifier.
// Depends on fblc_pkg.
module fblc_lane (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   sample,
  input  logic                   restart,
  input  logic                   pin,
  input  logic                   zc,
  input  logic                   rising,
  input  logic                   dis,
  input  fblc_pkg::limits_t      limits,
  output fblc_pkg::lane_status_t status
);
  import fblc_pkg::*;

  localparam logic signed [COUNT_W-1:0] COUNT_MAX  = COUNT_W'(127);
  localparam logic signed [COUNT_W-1:0] COUNT_MIN  = -COUNT_W'(127);
  localparam logic [LIMIT_W-1:0]        WINDOW_MAX = {LIMIT_W{1'b1}};

  function automatic logic signed [COUNT_W-1:0] bump(input logic signed [COUNT_W-1:0] v,
                                                     input logic up);
    logic signed [COUNT_W-1:0] r;
    if (up) begin
      r = (v < COUNT_MAX) ? v + COUNT_W'(1) : COUNT_MAX;
    end else begin
      r = (v > COUNT_MIN) ? v - COUNT_W'(1) : COUNT_MIN;
    end
    return r;
  endfunction

  logic signed [COUNT_W-1:0] level, level_next;
  logic signed [COUNT_W-1:0] phase, phase_next;
  logic [LIMIT_W-1:0]        window, window_next;
  logic                      zc_mode, zc_mode_next;
  logic [1:0]                value, value_next;
  logic                      ready, ready_next;
  logic                      wready, wready_next;

  logic signed [COUNT_W-1:0] lv_s, ph_s;
  logic [LIMIT_W-1:0]        win_s;
  logic                      zm_s;
  logic                      close;
  logic signed [COUNT_W-1:0] lim_l, lim_p;
  logic [COUNT_W-1:0]        lv_abs;
  logic                      cls_ok;
  logic [1:0]                cls_val;

  // Counts as they stand after this sample.
  always_comb begin
    lv_s  = bump(level, pin);
    ph_s  = zc ? bump(phase, rising ^ pin) : phase;
    zm_s  = zc ? zc_mode : 1'b0;
    win_s = (window < WINDOW_MAX) ? window + LIMIT_W'(1) : window;
    close = sample && (win_s >= limits.samples_per_decision);
  end

  always_comb begin
    lim_l   = $signed({1'b0, zm_s ? limits.zc_level_limit : limits.plain_level_limit});
    lim_p   = $signed({1'b0, limits.zc_phase_limit});
    lv_abs  = (lv_s < 0) ? COUNT_W'(-lv_s) : COUNT_W'(lv_s);
    cls_ok  = 1'b1;
    cls_val = VAL_LOW;
    priority if (lv_s >= lim_l) begin
      cls_val = VAL_HIGH;
    end else if (lv_s <= -lim_l) begin
      cls_val = VAL_LOW;
    end else if (!zm_s && lv_abs <= {1'b0, limits.plain_freq_limit}) begin
      cls_val = VAL_FREQ_IN;
    end else if (zm_s && ph_s >= lim_p) begin
      cls_val = VAL_FREQ_IN;
    end else if (zm_s && ph_s <= -lim_p) begin
      cls_val = VAL_FREQ_OPP;
    end else begin
      cls_ok = 1'b0;
    end
  end

  always_comb begin
    level_next   = level;
    phase_next   = phase;
    window_next  = window;
    zc_mode_next = zc_mode;
    value_next   = value;
    ready_next   = ready;
    wready_next  = wready;
    if (restart) begin
      level_next   = '0;
      phase_next   = '0;
      window_next  = '0;
      zc_mode_next = 1'b1;
      wready_next  = 1'b0;
    end else if (close) begin
      if (!dis && cls_ok) begin
        value_next = cls_val;
      end
      ready_next   = 1'b1;
      wready_next  = 1'b1;
      level_next   = '0;
      phase_next   = '0;
      window_next  = '0;
      zc_mode_next = 1'b1;
    end else if (sample) begin
      level_next   = lv_s;
      phase_next   = ph_s;
      window_next  = win_s;
      zc_mode_next = zm_s;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level   <= '0;
      phase   <= '0;
      window  <= '0;
      zc_mode <= 1'b0;
      value   <= VAL_LOW;
      ready   <= 1'b0;
      wready  <= 1'b0;
    end else begin
      level   <= level_next;
      phase   <= phase_next;
      window  <= window_next;
      zc_mode <= zc_mode_next;
      value   <= value_next;
      ready   <= ready_next;
      wready  <= wready_next;
    end
  end

  assign status = '{value: value_next, ready: ready_next, wready: wready_next, decided: close};
endmodule

[rtl/core/fblc_merge.sv]
// Merge stage: packs the lane status into one result and buffers it in a
// two-entry output register. Depends on fblc_pkg and fblc_rsp_if.
module fblc_merge #(
  parameter int LANES = fblc_pkg::CHANNELS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  fblc_pkg::lane_status_t      lanes [LANES],
  input  logic [fblc_pkg::MASK_W-1:0] active_mask,
  output logic                        in_ready,
  fblc_rsp_if.source                  rsp
);
  import fblc_pkg::*;

  result_t res_new;
  result_t out_data, skid_data;
  logic    out_valid, skid_valid;
  logic    pop;

  always_comb begin
    res_new = '0;
    res_new.all_active_ready = 1'b1;
    for (int c = 0; c < LANES; c++) begin
      res_new.channel_values[2*c +: 2]  = lanes[c].value;
      res_new.ready_mask[c]             = lanes[c].ready;
      res_new.writable_ready_mask[c]    = lanes[c].wready;
      res_new.decided_mask[c]           = lanes[c].decided;
      if (active_mask[c] && !lanes[c].ready) begin
        res_new.all_active_ready = 1'b0;
      end
    end
  end

  assign pop      = out_valid && rsp.ready;
  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // Payload: skid drains first, a new result lands in the free entry.
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_data <= skid_data;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_data <= res_new;
      end else begin
        out_data <= res_new;
      end
    end
  end

  assign rsp.valid               = out_valid;
  assign rsp.channel_values      = out_data.channel_values;
  assign rsp.ready_mask          = out_data.ready_mask;
  assign rsp.writable_ready_mask = out_data.writable_ready_mask;
  assign rsp.decided_mask        = out_data.decided_mask;
  assign rsp.all_active_ready    = out_data.all_active_ready;
endmodule

[rtl/core/feedback_level_freq_classifier.sv]
// Feedback level and frequency classifier top level: configuration registers,
// per-channel lanes and the merge stage. Depends on fblc_pkg, fblc_if, fblc_lane, fblc_merge.
//
//   port  dir   contents
//   req   sink  req_type, channel, pin_levels, load_type, zc_available, zc_await_rising
//   rsp   src   channel_values, ready_mask, writable_ready_mask, decided_mask, all_active_ready
//   cfg   sink  index, data (always ready)
//
// One item per cycle while req.ready is high; selected lanes update counters in that cycle.
// The result of each transfer is registered in the output buffer before it shows on rsp.
// A two-entry output buffer absorbs a stalled rsp; req.ready drops only when both are full.
// Synchronous reset clears all counters and flags at once; no clearing pass follows.
// Configuration writes take effect in the next cycle.
module feedback_level_freq_classifier #(
  parameter int CHANNELS = fblc_pkg::CHANNELS_DEFAULT
) (
  input logic      clk,
  input logic      rst,
  fblc_req_if.sink req,
  fblc_rsp_if.source rsp,
  fblc_cfg_if.sink cfg
);
  import fblc_pkg::*;

  // Only channels that fit the mask registers ever change state.
  localparam int LANES = (CHANNELS < MASK_W) ? CHANNELS : MASK_W;

  logic [MASK_W-1:0] active_mask, partial_mask, disable_mask;
  limits_t           limits;
  logic              accept;
  logic              in_ready;
  lane_status_t      lane_st [LANES];

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_mask                 <= '0;
      partial_mask                <= '0;
      disable_mask                <= '0;
      limits.samples_per_decision <= LIMIT_W'(16);
      limits.plain_level_limit    <= LIMIT_W'(12);
      limits.plain_freq_limit     <= LIMIT_W'(4);
      limits.zc_level_limit       <= LIMIT_W'(12);
      limits.zc_phase_limit       <= LIMIT_W'(12);
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_ACTIVE_MASK:          active_mask                 <= cfg.data;
        REG_PARTIAL_MASK:         partial_mask                <= cfg.data;
        REG_DISABLE_MASK:         disable_mask                <= cfg.data;
        REG_SAMPLES_PER_DECISION: limits.samples_per_decision <= cfg.data[LIMIT_W-1:0];
        REG_PLAIN_LEVEL_LIMIT:    limits.plain_level_limit    <= cfg.data[LIMIT_W-1:0];
        REG_PLAIN_FREQ_LIMIT:     limits.plain_freq_limit     <= cfg.data[LIMIT_W-1:0];
        REG_ZC_LEVEL_LIMIT:       limits.zc_level_limit       <= cfg.data[LIMIT_W-1:0];
        REG_ZC_PHASE_LIMIT:       limits.zc_phase_limit       <= cfg.data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign req.ready = in_ready;
  assign accept    = req.valid && in_ready;

  for (genvar c = 0; c < LANES; c++) begin : g_lane
    logic sample, restart;
    assign sample  = accept && (req.req_type == REQ_TICK) && active_mask[c]
                     && (partial_mask[c] == req.load_type);
    assign restart = accept && (req.req_type == REQ_RESTART) && (req.channel == CH_W'(c));

    fblc_lane u_lane (
      .clk     (clk),
      .rst     (rst),
      .sample  (sample),
      .restart (restart),
      .pin     (req.pin_levels[c]),
      .zc      (req.zc_available),
      .rising  (req.zc_await_rising),
      .dis     (disable_mask[c]),
      .limits  (limits),
      .status  (lane_st[c])
    );
  end

  fblc_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk         (clk),
    .rst         (rst),
    .push        (accept),
    .lanes       (lane_st),
    .active_mask (active_mask),
    .in_ready    (in_ready),
    .rsp         (rsp)
  );
endmodule

[rtl/core/fblc_checker.sv]
// Port-level checker for the classifier result channel, with its bind.
// Depends on fblc_pkg and feedback_level_freq_classifier_assert.svh.
`include "feedback_level_freq_classifier_assert.svh"

module fblc_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input logic [fblc_pkg::VALUES_W-1:0] channel_values,
  input logic [fblc_pkg::MASK_W-1:0] ready_mask,
  input logic [fblc_pkg::MASK_W-1:0] writable_ready_mask,
  input logic [fblc_pkg::MASK_W-1:0] decided_mask,
  input logic                        all_active_ready
);
  import fblc_pkg::*;

  // A channel that just closed its window is ready in both senses.
  `FBLC_ASSERT_HOLDS(a_decided_ready, !rsp_valid || ((decided_mask & ~ready_mask) == '0), "decided channel not ready")
  `FBLC_ASSERT_HOLDS(a_decided_wready, !rsp_valid || ((decided_mask & ~writable_ready_mask) == '0), "decided channel not writable ready")
  // Ready since restart implies ready since reset.
  `FBLC_ASSERT_HOLDS(a_wready_subset, !rsp_valid || ((writable_ready_mask & ~ready_mask) == '0), "writable ready without ready")
  `FBLC_ASSERT_NEXT(a_stall_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(channel_values) && $stable(ready_mask) && $stable(writable_ready_mask) && $stable(decided_mask) && $stable(all_active_ready), "stalled result changed")
endmodule

bind feedback_level_freq_classifier fblc_checker u_fblc_checker (
  .clk                 (clk),
  .rst                 (rst),
  .rsp_valid           (rsp.valid),
  .rsp_ready           (rsp.ready),
  .channel_values      (rsp.channel_values),
  .ready_mask          (rsp.ready_mask),
  .writable_ready_mask (rsp.writable_ready_mask),
  .decided_mask        (rsp.decided_mask),
  .all_active_ready    (rsp.all_active_ready)
);

[sim/tb_feedback_level_freq_classifier.sv]
// Self-checking testbench for feedback_level_freq_classifier: a directed set, then random
// phases under changing settings, each result checked against a lane-by-lane predictor.
// Depends on fblc_pkg, the fblc_*_if interfaces and the classifier RTL.
module tb_feedback_level_freq_classifier;
  import fblc_pkg::*;

  localparam int NCH        = CHANNELS_DEFAULT;
  localparam int IDLE_LIMIT = 3000;
  localparam int HOLD_LEN   = 400;
  localparam int PHASES     = 9;
  localparam int PHASE_LEN  = 128;

  typedef struct packed {
    req_type_e         kind;
    logic [CH_W-1:0]   channel;
    logic [MASK_W-1:0] pins;
    logic              load;
    logic              zc;
    logic              rising;
  } sample_req_t;

  // Predicts every result from the accepted requests and register writes.
  class classifier_model;
    logic [7:0] active = '0, partial = '0, disabled = '0;
    logic [6:0] spd = 7'd16, plain_lvl = 7'd12, plain_frq = 7'd4;
    logic [6:0] zc_lvl = 7'd12, zc_phs = 7'd12;
    bit [1:0]   stored [NCH];
    int         lvl [NCH];
    int         phs [NCH];
    int         win [NCH];
    bit         zc_mode [NCH];
    bit         rdy [NCH];
    bit         wrdy [NCH];
    result_t    pending_results [$];
    int unsigned mismatches = 0, decisions = 0, requests = 0, results = 0;

    function void write_reg(cfg_reg_e idx, logic [7:0] d);
      case (idx)
        REG_ACTIVE_MASK:          active = d;
        REG_PARTIAL_MASK:         partial = d;
        REG_DISABLE_MASK:         disabled = d;
        REG_SAMPLES_PER_DECISION: spd = d[6:0];
        REG_PLAIN_LEVEL_LIMIT:    plain_lvl = d[6:0];
        REG_PLAIN_FREQ_LIMIT:     plain_frq = d[6:0];
        REG_ZC_LEVEL_LIMIT:       zc_lvl = d[6:0];
        REG_ZC_PHASE_LIMIT:       zc_phs = d[6:0];
        default: ;
      endcase
    endfunction

    function int bump(int v, bit up);
      if (up) return (v < 127) ? v + 1 : 127;
      return (v > -127) ? v - 1 : -127;
    endfunction

    function void clear_window(int c);
      lvl[c] = 0;
      phs[c] = 0;
      win[c] = 0;
      zc_mode[c] = 1'b1;
    endfunction

    // -1 when the window gives no verdict
    function int classify_window(int c);
      int mag;
      mag = (lvl[c] < 0) ? -lvl[c] : lvl[c];
      if (!zc_mode[c]) begin
        if (lvl[c] >= int'(plain_lvl)) return int'(VAL_HIGH);
        if (lvl[c] <= -int'(plain_lvl)) return int'(VAL_LOW);
        if (mag <= int'(plain_frq)) return int'(VAL_FREQ_IN);
        return -1;
      end
      if (lvl[c] >= int'(zc_lvl)) return int'(VAL_HIGH);
      if (lvl[c] <= -int'(zc_lvl)) return int'(VAL_LOW);
      if (phs[c] >= int'(zc_phs)) return int'(VAL_FREQ_IN);
      if (phs[c] <= -int'(zc_phs)) return int'(VAL_FREQ_OPP);
      return -1;
    endfunction

    function void note_request(sample_req_t it);
      result_t r;
      logic [7:0] decided;
      bit pin;
      bit match;
      int v;
      decided = '0;
      requests++;
      if (it.kind == REQ_RESTART) begin
        clear_window(int'(it.channel));
        wrdy[it.channel] = 1'b0;
      end else begin
        for (int c = 0; c < NCH; c++) begin
          if (active[c] && partial[c] == it.load) begin
            pin = it.pins[c];
            lvl[c] = bump(lvl[c], pin);
            if (it.zc) begin
              match = it.rising ? !pin : pin;
              phs[c] = bump(phs[c], match);
            end else begin
              zc_mode[c] = 1'b0;
            end
            if (win[c] < 127) win[c]++;
            if (win[c] >= int'(spd)) begin
              v = classify_window(c);
              if (!disabled[c] && v >= 0) stored[c] = v[1:0];
              rdy[c] = 1'b1;
              wrdy[c] = 1'b1;
              clear_window(c);
              decided[c] = 1'b1;
              decisions++;
            end
          end
        end
      end
      r = '0;
      r.all_active_ready = 1'b1;
      for (int c = 0; c < NCH; c++) begin
        r.channel_values[2*c +: 2] = stored[c];
        r.ready_mask[c] = rdy[c];
        r.writable_ready_mask[c] = wrdy[c];
        if (active[c] && !rdy[c]) r.all_active_ready = 1'b0;
      end
      r.decided_mask = decided;
      pending_results.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t exp;
      results++;
      if (pending_results.size() == 0) begin
        $error("result arrived with nothing expected: %h", got);
        mismatches++;
        return;
      end
      exp = pending_results.pop_front();
      if (got.channel_values !== exp.channel_values) begin
        $error("channel_values: expected %h, actual %h", exp.channel_values, got.channel_values);
        mismatches++;
      end
      if (got.ready_mask !== exp.ready_mask) begin
        $error("ready_mask: expected %h, actual %h", exp.ready_mask, got.ready_mask);
        mismatches++;
      end
      if (got.writable_ready_mask !== exp.writable_ready_mask) begin
        $error("writable_ready_mask: expected %h, actual %h",
               exp.writable_ready_mask, got.writable_ready_mask);
        mismatches++;
      end
      if (got.decided_mask !== exp.decided_mask) begin
        $error("decided_mask: expected %h, actual %h", exp.decided_mask, got.decided_mask);
        mismatches++;
      end
      if (got.all_active_ready !== exp.all_active_ready) begin
        $error("all_active_ready: expected %b, actual %b",
               exp.all_active_ready, got.all_active_ready);
        mismatches++;
      end
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  fblc_req_if req_ch ();
  fblc_rsp_if rsp_ch ();
  fblc_cfg_if cfg_ch ();

  feedback_level_freq_classifier #(.CHANNELS(NCH)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  classifier_model model = new;

  // stimulus shaping, set per phase
  int unsigned max_burst = 8, max_gap = 4;
  int unsigned noise_pct = 10, restart_pct = 5, zc_pct = 80, load_one_pct = 50;
  int unsigned lane_kind [NCH];
  bit          rise_state = 1'b0;
  int unsigned burst_left = 0;
  int unsigned settings = 0;
  // receiver behavior
  int unsigned sink_mode = 0;
  bit          hold_request = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // sample every transfer at the rising edge
  always @(posedge clk) begin
    sample_req_t it;
    result_t     got;
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) model.write_reg(cfg_reg_e'(cfg_ch.index), cfg_ch.data);
      if (req_ch.valid && req_ch.ready) begin
        it.kind    = req_type_e'(req_ch.req_type);
        it.channel = req_ch.channel;
        it.pins    = req_ch.pin_levels;
        it.load    = req_ch.load_type;
        it.zc      = req_ch.zc_available;
        it.rising  = req_ch.zc_await_rising;
        model.note_request(it);
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.channel_values      = rsp_ch.channel_values;
        got.ready_mask          = rsp_ch.ready_mask;
        got.writable_ready_mask = rsp_ch.writable_ready_mask;
        got.decided_mask        = rsp_ch.decided_mask;
        got.all_active_ready    = rsp_ch.all_active_ready;
        model.check_result(got);
      end
    end
  end

  // receiver: own stall pattern, plus a long hold-off on request
  initial begin
    int unsigned hold_left;
    int unsigned pat_pos;
    logic [10:0] stall_pattern;
    hold_left = 0;
    pat_pos = 0;
    stall_pattern = 11'b101_1011_1011;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        case (sink_mode)
          0: rsp_ch.ready <= 1'b1;
          1: rsp_ch.ready <= ($urandom_range(99) < 70);
          default: begin
            rsp_ch.ready <= stall_pattern[pat_pos];
            pat_pos = (pat_pos + 1) % 11;
          end
        endcase
      end
    end
  end

  // watchdog: end the run when nothing has moved for too long
  initial begin
    int unsigned idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        idle = 0;
      else
        idle++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic drive_request(sample_req_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      if (max_gap > 0 && req_ch.valid) begin
        @(negedge clk);
        req_ch.valid <= 1'b0;
        gap = $urandom_range(max_gap - 1);
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(max_burst, 1);
    end
    burst_left--;
    @(negedge clk);
    req_ch.valid           <= 1'b1;
    req_ch.req_type        <= it.kind;
    req_ch.channel         <= it.channel;
    req_ch.pin_levels      <= it.pins;
    req_ch.load_type       <= it.load;
    req_ch.zc_available    <= it.zc;
    req_ch.zc_await_rising <= it.rising;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // stop offering and wait until every expected result is in
  task automatic drain();
    if (req_ch.valid) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
    end
    burst_left = 0;
    @(negedge clk);
    while (model.outstanding() != 0) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [7:0] d);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= d;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_config(logic [7:0] act, logic [7:0] part, logic [7:0] dis,
                            logic [7:0] spd, logic [7:0] pl, logic [7:0] pf,
                            logic [7:0] zl, logic [7:0] zp);
    drain();
    write_reg(REG_ACTIVE_MASK, act);
    write_reg(REG_PARTIAL_MASK, part);
    write_reg(REG_DISABLE_MASK, dis);
    write_reg(REG_SAMPLES_PER_DECISION, spd);
    write_reg(REG_PLAIN_LEVEL_LIMIT, pl);
    write_reg(REG_PLAIN_FREQ_LIMIT, pf);
    write_reg(REG_ZC_LEVEL_LIMIT, zl);
    write_reg(REG_ZC_PHASE_LIMIT, zp);
    settings++;
  endtask

  function automatic sample_req_t mk(req_type_e kind, int ch, logic [7:0] pins,
                                     bit load, bit zc, bit rising);
    sample_req_t it;
    it.kind    = kind;
    it.channel = ch[CH_W-1:0];
    it.pins    = pins;
    it.load    = load;
    it.zc      = zc;
    it.rising  = rising;
    return it;
  endfunction

  // mostly coherent pin patterns per lane, with noise and restarts mixed in
  function automatic sample_req_t next_request();
    sample_req_t it;
    int unsigned roll;
    bit pin;
    it = mk(req_type_e'($urandom_range(1)), $urandom_range(7), 8'($urandom),
            1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
    roll = $urandom_range(99);
    if (roll < noise_pct) return it;
    if (roll < noise_pct + restart_pct) begin
      it.kind = REQ_RESTART;
      return it;
    end
    it.kind = REQ_TICK;
    rise_state = ~rise_state;
    it.rising = rise_state;
    it.zc = ($urandom_range(99) < zc_pct);
    it.load = ($urandom_range(99) < load_one_pct);
    for (int c = 0; c < NCH; c++) begin
      case (lane_kind[c])
        0: pin = 1'b1;
        1: pin = 1'b0;
        2: pin = !rise_state;
        3: pin = rise_state;
        default: pin = 1'($urandom_range(1));
      endcase
      if ($urandom_range(99) < 8) pin = !pin;
      it.pins[c] = pin;
    end
    return it;
  endfunction

  task automatic directed_part();
    // one-sample windows; the first window after reset classifies without zero crossing
    set_config(8'hFF, 8'hF0, 8'h00, 8'd1, 8'd12, 8'd4, 8'd12, 8'd1);
    drive_request(mk(REQ_TICK, 0, 8'h00, 1'b0, 1'b1, 1'b1));
    drive_request(mk(REQ_TICK, 0, 8'hFF, 1'b1, 1'b0, 1'b0));
    drive_request(mk(REQ_TICK, 0, 8'h0F, 1'b0, 1'b1, 1'b1));
    drive_request(mk(REQ_TICK, 0, 8'h00, 1'b0, 1'b1, 1'b1));
    drive_request(mk(REQ_TICK, 0, 8'hFF, 1'b0, 1'b1, 1'b0));
    drive_request(mk(REQ_TICK, 0, 8'h00, 1'b1, 1'b1, 1'b0));
    drive_request(mk(REQ_RESTART, 0, 8'hFF, 1'b1, 1'b1, 1'b1));
    drive_request(mk(REQ_RESTART, 7, 8'h00, 1'b0, 1'b0, 1'b0));
    drive_request(mk(REQ_TICK, 0, 8'hAA, 1'b0, 1'b0, 1'b1));
    drive_request(mk(REQ_TICK, 0, 8'h55, 1'b1, 1'b1, 1'b1));
    // zero window length closes on every sample; half the lanes keep their value
    set_config(8'hFF, 8'h0F, 8'hAA, 8'd0, 8'd1, 8'd0, 8'd1, 8'd1);
    drive_request(mk(REQ_TICK, 0, 8'hFF, 1'b0, 1'b1, 1'b0));
    drive_request(mk(REQ_TICK, 0, 8'h00, 1'b1, 1'b0, 1'b1));
    drive_request(mk(REQ_TICK, 0, 8'hFF, 1'b1, 1'b1, 1'b1));
    drive_request(mk(REQ_TICK, 0, 8'h00, 1'b0, 1'b1, 1'b0));
    // no active lane, then two lanes with zero thresholds
    set_config(8'h00, 8'h00, 8'hFF, 8'd127, 8'd127, 8'd127, 8'd127, 8'd127);
    drive_request(mk(REQ_TICK, 0, 8'hFF, 1'b0, 1'b1, 1'b1));
    drive_request(mk(REQ_RESTART, 3, 8'h00, 1'b0, 1'b0, 1'b0));
    set_config(8'h81, 8'h00, 8'h00, 8'd3, 8'd0, 8'd0, 8'd0, 8'd0);
    drive_request(mk(REQ_TICK, 0, 8'h01, 1'b0, 1'b0, 1'b0));
    drive_request(mk(REQ_TICK, 0, 8'h80, 1'b0, 1'b1, 1'b1));
    drive_request(mk(REQ_TICK, 0, 8'h00, 1'b0, 1'b1, 1'b0));
    drive_request(mk(REQ_TICK, 0, 8'hFF, 1'b1, 1'b1, 1'b0));
    drive_request(mk(REQ_TICK, 0, 8'hFF, 1'b0, 1'b0, 1'b1));
    drive_request(mk(REQ_RESTART, 0, 8'hFF, 1'b0, 1'b1, 1'b0));
  endtask

  task automatic random_phase(int p);
    logic [7:0] spd;
    int unsigned top;
    case (p)
      0: begin
        // widest window, every limit at its top; restarts would keep it from closing
        set_config(8'hFF, 8'h00, 8'h00, 8'd127, 8'd127, 8'd127, 8'd127, 8'd127);
        restart_pct = 0; noise_pct = 0; load_one_pct = 0; zc_pct = 100;
      end
      1: begin
        set_config(8'hFF, 8'h00, 8'h00, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0);
        restart_pct = 5; noise_pct = 10; load_one_pct = 30; zc_pct = 50;
      end
      default: begin
        case ($urandom_range(9))
          0, 1, 2, 3, 4, 5, 6: spd = 8'($urandom_range(10, 1));
          7, 8:                spd = 8'($urandom_range(40, 11));
          default:             spd = 8'($urandom_range(127, 41));
        endcase
        top = (spd + 2 > 127) ? 127 : spd + 2;
        set_config(($urandom_range(3) == 0) ? 8'hFF : 8'($urandom),
                   8'($urandom),
                   ($urandom_range(2) == 0) ? 8'h00 : 8'($urandom),
                   spd,
                   8'($urandom_range(top)), 8'($urandom_range(top / 2)),
                   8'($urandom_range(top)), 8'($urandom_range(top)));
        restart_pct = $urandom_range(8, 1);
        noise_pct = $urandom_range(15, 3);
        load_one_pct = $urandom_range(100);
        zc_pct = ($urandom_range(3) == 0) ? 100 : $urandom_range(100);
      end
    endcase
    for (int c = 0; c < NCH; c++) lane_kind[c] = $urandom_range(4);
    sink_mode = p % 3;
    if (p % 4 == 2) begin
      max_gap = 0;
      sink_mode = 0;
    end else begin
      max_gap = $urandom_range(8, 1);
    end
    max_burst = $urandom_range(16, 1);
    if (p == 4) hold_request = 1'b1;
    for (int i = 0; i < PHASE_LEN; i++) begin
      if (p == 5 && i == PHASE_LEN / 2) drain();
      drive_request(next_request());
    end
  endtask

  initial begin
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.req_type <= REQ_TICK;
    req_ch.channel <= '0;
    req_ch.pin_levels <= '0;
    req_ch.load_type <= 1'b0;
    req_ch.zc_available <= 1'b0;
    req_ch.zc_await_rising <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= REG_ACTIVE_MASK;
    cfg_ch.data <= '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    directed_part();
    for (int p = 0; p < PHASES; p++) random_phase(p);
    drain();
    repeat (10) @(negedge clk);
    $display("Run covered %0d requests and %0d results, %0d lane decisions, %0d settings.",
             model.requests, model.results, model.decisions, settings);
    if (model.mismatches == 0 && model.outstanding() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
